@@ rtl/lpg_pkg.sv @@
// Package for the line pixel generator.
// Holds the frame geometry, field widths and the operation codes; no dependencies.
package lpg_pkg;

  // Frame width in pixels, used for the linear pixel index.
  localparam int unsigned WIDTH = 640;

  // Field widths of the item payloads.
  localparam int unsigned COL_W = 10;
  localparam int unsigned ROW_W = 9;
  localparam int unsigned IDX_W = 19;
  localparam int unsigned CLR_W = 8;

  // Product of row span and column offset, the dividend of the walk.
  localparam int unsigned PROD_W = ROW_W + COL_W;

  // Width of the divider's step counter, which counts down from PROD_W.
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W + 1);

  // Operation codes carried on the input channel.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

@@ rtl/lpg_in_if.sv @@
// Input channel of the line pixel generator: valid/ready handshake plus load/step payload.
// Depends on lpg_pkg for field widths.
interface lpg_in_if
  import lpg_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [COL_W-1:0] x_start;
  logic [ROW_W-1:0] y_start;
  logic [COL_W-1:0] x_end;
  logic [ROW_W-1:0] y_end;
  logic [CLR_W-1:0] red_in;
  logic [CLR_W-1:0] green_in;
  logic [CLR_W-1:0] blue_in;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
    output ready
  );
endinterface

@@ rtl/lpg_out_if.sv @@
// Output channel of the line pixel generator: valid/ready handshake plus pixel payload.
// Depends on lpg_pkg for field widths.
interface lpg_out_if
  import lpg_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] pixel_x;
  logic [ROW_W-1:0] pixel_y;
  logic [IDX_W-1:0] pixel_index;
  logic [CLR_W-1:0] red_out;
  logic [CLR_W-1:0] green_out;
  logic [CLR_W-1:0] blue_out;
  logic             last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_index, red_out, green_out, blue_out, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_index, red_out, green_out, blue_out, last_pixel,
    output ready
  );
endinterface

@@ rtl/line_pixel_generator_core.sv @@
// Line pixel generator: a load stores a line and colour, a step on a loaded line gives one pixel.
// Depends on lpg_pkg, lpg_in_if, lpg_out_if and lpg_divider.
//
// A load item gives no pixel. A step item on a sloped line passes these steps before its
// pixel sits in the output register: acceptance, the product of row span and column offset,
// the radix-2 divider and the finish; a step on a vertical line skips the product and the
// divider. The input is not ready while a step is in progress, but a finished pixel may
// wait at the output while the next item is accepted. Steps given with no line loaded
// are absorbed and give nothing.
module line_pixel_generator_core
  import lpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lpg_in_if.sink    line_in,
  lpg_out_if.source pixel_out
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t            state;
  logic              active;
  logic              vertical_mode;
  logic [COL_W-1:0]  column_now;
  logic [COL_W-1:0]  column_left;
  logic [COL_W-1:0]  column_stop;
  logic [ROW_W-1:0]  row_left;
  logic [ROW_W-1:0]  row_span;
  logic              row_descends;
  logic [ROW_W-1:0]  row_now;
  logic [ROW_W-1:0]  row_stop;
  logic [CLR_W-1:0]  colour_r;
  logic [CLR_W-1:0]  colour_g;
  logic [CLR_W-1:0]  colour_b;
  logic [ROW_W-1:0]  row_walk;

  logic              out_valid;
  logic [COL_W-1:0]  out_x;
  logic [ROW_W-1:0]  out_y;
  logic [IDX_W-1:0]  out_index;
  logic [CLR_W-1:0]  out_r;
  logic [CLR_W-1:0]  out_g;
  logic [CLR_W-1:0]  out_b;
  logic              out_last;

  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] dividend;
  logic [COL_W-1:0]  span_x;
  logic [COL_W-1:0]  offset;
  logic [PROD_W-1:0] quotient;

  logic              in_fire;
  logic              out_free;
  logic [ROW_W-1:0]  pix_y;
  logic              pix_last;
  logic [IDX_W-1:0]  pix_index;
  logic              load_left;

  // Product of row span and column offset feeds the divider's dividend register.
  assign span_x    = column_stop - column_left;
  assign offset    = column_now - column_left;
  assign dividend  = PROD_W'(row_span) * PROD_W'(offset);
  assign div_start = (state == ST_MUL);

  lpg_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span_x),
    .done     (div_done),
    .quotient (quotient)
  );

  // Pixel row, last flag and linear index for the pixel being issued.
  always_comb begin
    if (vertical_mode) begin
      pix_y    = row_now;
      pix_last = (row_now == row_stop);
    end else if (row_descends) begin
      pix_y    = row_left - quotient[ROW_W-1:0];
      pix_last = (column_now == column_stop);
    end else begin
      pix_y    = row_left + quotient[ROW_W-1:0];
      pix_last = (column_now == column_stop);
    end
    pix_index = IDX_W'(column_now) + IDX_W'(IDX_W'(WIDTH) * IDX_W'(pix_y));
    row_walk  = row_descends ? row_now - 1'b1 : row_now + 1'b1;
  end

  assign in_fire   = line_in.valid && line_in.ready;
  assign out_free  = !out_valid || pixel_out.ready;
  assign load_left = line_in.x_end > line_in.x_start;

  // Sequencer, line state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output register empties when its item is taken, unless a new pixel replaces it.
      if (pixel_out.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (line_in.operation == OP_LOAD) begin
              // Store the new line, ordered left to right.
              active   <= 1'b1;
              colour_r <= line_in.red_in;
              colour_g <= line_in.green_in;
              colour_b <= line_in.blue_in;
              if (line_in.x_start == line_in.x_end) begin
                vertical_mode <= 1'b1;
                column_now    <= line_in.x_start;
                column_left   <= line_in.x_start;
                column_stop   <= line_in.x_start;
                row_now       <= line_in.y_start;
                row_left      <= line_in.y_start;
                row_stop      <= line_in.y_end;
                row_descends  <= line_in.y_end < line_in.y_start;
                row_span      <= (line_in.y_end < line_in.y_start) ?
                                 line_in.y_start - line_in.y_end :
                                 line_in.y_end - line_in.y_start;
              end else if (load_left) begin
                vertical_mode <= 1'b0;
                column_now    <= line_in.x_start;
                column_left   <= line_in.x_start;
                column_stop   <= line_in.x_end;
                row_now       <= line_in.y_start;
                row_left      <= line_in.y_start;
                row_stop      <= line_in.y_end;
                row_descends  <= line_in.y_end < line_in.y_start;
                row_span      <= (line_in.y_end < line_in.y_start) ?
                                 line_in.y_start - line_in.y_end :
                                 line_in.y_end - line_in.y_start;
              end else begin
                vertical_mode <= 1'b0;
                column_now    <= line_in.x_end;
                column_left   <= line_in.x_end;
                column_stop   <= line_in.x_start;
                row_now       <= line_in.y_end;
                row_left      <= line_in.y_end;
                row_stop      <= line_in.y_start;
                row_descends  <= line_in.y_start < line_in.y_end;
                row_span      <= (line_in.y_start < line_in.y_end) ?
                                 line_in.y_end - line_in.y_start :
                                 line_in.y_start - line_in.y_end;
              end
            end else if (active) begin
              state <= vertical_mode ? ST_EMIT : ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Issue the pixel once the output register can take it, then advance the walk.
          if (out_free) begin
            out_valid <= 1'b1;
            out_x     <= column_now;
            out_y     <= pix_y;
            out_index <= pix_index;
            out_r     <= colour_r;
            out_g     <= colour_g;
            out_b     <= colour_b;
            out_last  <= pix_last;
            state     <= ST_IDLE;
            if (pix_last) begin
              active <= 1'b0;
            end
            if (vertical_mode) begin
              if (!pix_last) begin
                row_now <= row_walk;
              end
            end else begin
              row_now <= pix_y;
              if (!pix_last) begin
                column_now <= column_now + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign line_in.ready         = (state == ST_IDLE);
  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_x     = out_x;
  assign pixel_out.pixel_y     = out_y;
  assign pixel_out.pixel_index = out_index;
  assign pixel_out.red_out     = out_r;
  assign pixel_out.green_out   = out_g;
  assign pixel_out.blue_out    = out_b;
  assign pixel_out.last_pixel  = out_last;

endmodule

@@ rtl/lpg_divider.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on lpg_pkg for the dividend and divisor widths.
module lpg_divider
  import lpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [COL_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [PROD_W-1:0]    quot;
  logic [COL_W-1:0]     rem;
  logic [COL_W-1:0]     div_reg;
  logic [COL_W:0]       trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial = {rem, quot[PROD_W-1]};
  assign fits  = trial >= {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        count   <= DIV_CNT_W'(PROD_W);
        quot    <= dividend;
        rem     <= '0;
        div_reg <= divisor;
      end else if (busy) begin
        // One restoring step: subtract when the divisor fits.
        if (fits) begin
          rem <= COL_W'(trial - {1'b0, div_reg});
        end else begin
          rem <= trial[COL_W-1:0];
        end
        quot  <= {quot[PROD_W-2:0], fits};
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quot;

endmodule

@@ tb/tb_line_pixel_generator_core.sv @@
// Self-checking testbench for line_pixel_generator_core: directed rows, then random lines.
// Depends on lpg_pkg, lpg_in_if, lpg_out_if and the core itself; a shadow walk predicts pixels.
module tb_line_pixel_generator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lpg_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned MAX_IDLE     = 11;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef struct packed {
    logic             operation;
    logic [COL_W-1:0] x_start;
    logic [ROW_W-1:0] y_start;
    logic [COL_W-1:0] x_end;
    logic [ROW_W-1:0] y_end;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
  } line_item_t;

  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [IDX_W-1:0] index;
    logic [CLR_W-1:0] red;
    logic [CLR_W-1:0] green;
    logic [CLR_W-1:0] blue;
    logic             last;
  } pixel_t;

  // A directed row either trusts the shadow walk or carries a typed-in pixel.
  typedef struct {
    line_item_t item;
    bit         pinned;
    pixel_t     pinned_px;
  } directed_row_t;

  logic clk;
  logic rst;

  lpg_in_if  line_if ();
  lpg_out_if pix_if ();

  line_pixel_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .line_in  (line_if),
    .pixel_out(pix_if)
  );

  // Shadow copy of the line walk, starting from the reset state.
  bit               walk_active   = 1'b0;
  bit               walk_vertical = 1'b0;
  bit               row_down      = 1'b0;
  logic [COL_W-1:0] col_now       = '0;
  logic [COL_W-1:0] col_left      = '0;
  logic [COL_W-1:0] col_stop      = '0;
  logic [ROW_W-1:0] row_left      = '0;
  logic [ROW_W-1:0] row_span      = '0;
  logic [ROW_W-1:0] row_now       = '0;
  logic [ROW_W-1:0] row_stop      = '0;
  logic [3*CLR_W-1:0] line_rgb    = '0;

  pixel_t      pending_pixels[$];
  int unsigned items_sent;
  int unsigned lines_loaded;
  int unsigned pixels_seen;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned ready_hold;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advances the shadow walk by one item; returns 1 when the item yields a pixel.
  function automatic bit next_pixel(input line_item_t it, output pixel_t px);
    int unsigned      span_x;
    int unsigned      offset;
    int unsigned      quot;
    int unsigned      row_calc;
    int unsigned      idx;
    logic [COL_W-1:0] col_px;
    logic [ROW_W-1:0] row_px;
    bit               last;
    px = '0;
    if (it.operation == OP_LOAD) begin
      line_rgb    = {it.red, it.green, it.blue};
      walk_active = 1'b1;
      if (it.x_start == it.x_end) begin
        walk_vertical = 1'b1;
        col_now  = it.x_start;
        col_left = it.x_start;
        col_stop = it.x_start;
        row_left = it.y_start;
        row_now  = it.y_start;
        row_stop = it.y_end;
      end else begin
        walk_vertical = 1'b0;
        if (it.x_end > it.x_start) begin
          col_left = it.x_start;
          col_stop = it.x_end;
          row_left = it.y_start;
          row_stop = it.y_end;
        end else begin
          col_left = it.x_end;
          col_stop = it.x_start;
          row_left = it.y_end;
          row_stop = it.y_start;
        end
        col_now = col_left;
        row_now = row_left;
      end
      row_down = row_stop < row_left;
      row_span = row_down ? row_left - row_stop : row_stop - row_left;
      return 1'b0;
    end
    if (!walk_active) begin
      return 1'b0;
    end
    if (walk_vertical) begin
      // Vertical lines step one row at a time toward the end row.
      last   = row_now == row_stop;
      col_px = col_now;
      row_px = row_now;
      if (last) begin
        walk_active = 1'b0;
      end else if (row_down) begin
        row_now = row_now - 1'b1;
      end else begin
        row_now = row_now + 1'b1;
      end
    end else begin
      // Sloped lines step one column and take the truncated row offset.
      span_x = col_stop - col_left;
      offset = col_now - col_left;
      if (span_x == 0) begin
        span_x = 1;
      end
      quot     = (row_span * offset) / span_x;
      row_calc = row_down ? row_left - quot : row_left + quot;
      row_px   = row_calc[ROW_W-1:0];
      row_now  = row_px;
      col_px   = col_now;
      last     = col_now == col_stop;
      if (last) begin
        walk_active = 1'b0;
      end else begin
        col_now = col_now + 1'b1;
      end
    end
    idx      = col_px + WIDTH * row_px;
    px.x     = col_px;
    px.y     = row_px;
    px.index = idx[IDX_W-1:0];
    px.red   = line_rgb[3*CLR_W-1:2*CLR_W];
    px.green = line_rgb[2*CLR_W-1:CLR_W];
    px.blue  = line_rgb[CLR_W-1:0];
    px.last  = last;
    return 1'b1;
  endfunction

  function automatic line_item_t random_item(input logic op);
    line_item_t it;
    it.operation = op;
    it.x_start   = COL_W'($urandom_range(0, 1023));
    it.y_start   = ROW_W'($urandom_range(0, 511));
    it.x_end     = COL_W'($urandom_range(0, 1023));
    it.y_end     = ROW_W'($urandom_range(0, 511));
    it.red       = CLR_W'($urandom_range(0, 255));
    it.green     = CLR_W'($urandom_range(0, 255));
    it.blue      = CLR_W'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic line_item_t load_item(input int unsigned xs, input int unsigned ys,
                                           input int unsigned xe, input int unsigned ye,
                                           input logic [CLR_W-1:0] r,
                                           input logic [CLR_W-1:0] g,
                                           input logic [CLR_W-1:0] b);
    line_item_t it;
    it.operation = OP_LOAD;
    it.x_start   = COL_W'(xs);
    it.y_start   = ROW_W'(ys);
    it.x_end     = COL_W'(xe);
    it.y_end     = ROW_W'(ye);
    it.red       = r;
    it.green     = g;
    it.blue      = b;
    return it;
  endfunction

  // Builds a load for a line of random placement and returns how many pixels it has.
  task automatic make_random_line(output line_item_t it, output int unsigned len);
    int unsigned kind;
    int unsigned span;
    int          d;
    int          end_i;
    kind = $urandom_range(0, 99);
    it   = random_item(OP_LOAD);
    if (kind < 20) begin
      d     = $urandom_range(0, 12);
      end_i = int'(it.y_start) + ($urandom_range(0, 1) ? d : -d);
      if (end_i < 0 || end_i > 511) begin
        end_i = 2 * int'(it.y_start) - end_i;
      end
      it.x_end = it.x_start;
      it.y_end = ROW_W'(end_i);
      len      = d + 1;
    end else begin
      span  = (kind < 22) ? $urandom_range(64, 255) : $urandom_range(1, 16);
      end_i = int'(it.x_start) + ($urandom_range(0, 1) ? int'(span) : -int'(span));
      if (end_i < 0 || end_i > 1023) begin
        end_i = 2 * int'(it.x_start) - end_i;
      end
      it.x_end = COL_W'(end_i);
      if ($urandom_range(0, 9) == 0) begin
        it.y_end = it.y_start;
      end
      len = span + 1;
    end
  endtask

  // Drives one item after a random gap, waits for acceptance and records the expected pixel.
  task automatic send_line_item(input line_item_t it, input bit pinned, input pixel_t pinned_px);
    int unsigned gap;
    pixel_t      px;
    bit          makes_pixel;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      line_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_if.valid     <= 1'b1;
    line_if.operation <= it.operation;
    line_if.x_start   <= it.x_start;
    line_if.y_start   <= it.y_start;
    line_if.x_end     <= it.x_end;
    line_if.y_end     <= it.y_end;
    line_if.red_in    <= it.red;
    line_if.green_in  <= it.green;
    line_if.blue_in   <= it.blue;
    do @(posedge clk); while (line_if.ready !== 1'b1);
    makes_pixel = next_pixel(it, px);
    if (pinned) begin
      pending_pixels.push_back(pinned_px);
    end else if (makes_pixel) begin
      pending_pixels.push_back(px);
    end
    items_sent++;
    if (it.operation == OP_LOAD) begin
      lines_loaded++;
    end
  endtask

  // Holds the input off until every expected pixel is out and the core has settled.
  task automatic hold_until_drained();
    line_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Pixel receiver: checks each accepted pixel and stalls ready at random.
  always @(posedge clk) begin
    pixel_t      got;
    pixel_t      exp;
    int unsigned stall;
    if (rst) begin
      pix_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
      got = {pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_index, pix_if.red_out,
             pix_if.green_out, pix_if.blue_out, pix_if.last_pixel};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d idx=%0d rgb=%h%h%h last=%b", $time,
                 got.x, got.y, got.index, got.red, got.green, got.blue, got.last);
        errors++;
      end else begin
        exp = pending_pixels.pop_front();
        if (got !== exp) begin
          $display("%0t: pixel mismatch, expected x=%0d y=%0d idx=%0d rgb=%h%h%h last=%b",
                   $time, exp.x, exp.y, exp.index, exp.red, exp.green, exp.blue, exp.last);
          $display("%0t:                   actual x=%0d y=%0d idx=%0d rgb=%h%h%h last=%b",
                   $time, got.x, got.y, got.index, got.red, got.green, got.blue, got.last);
          errors++;
        end
        pixels_seen++;
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      ready_hold   <= stall;
      pix_if.ready <= (stall == 0);
    end else if (pix_if.ready !== 1'b1) begin
      if (ready_hold <= 1) begin
        pix_if.ready <= 1'b1;
      end
      if (ready_hold != 0) begin
        ready_hold <= ready_hold - 1;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (line_if.valid === 1'b1 && line_if.ready === 1'b1) ||
        (pix_if.valid === 1'b1 && pix_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d pixels outstanding", $time,
               quiet_cycles, pending_pixels.size());
      $display("tb_line_pixel_generator_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, directed rows, then random lines with their steps.
  initial begin
    directed_row_t directed_rows[$];
    line_item_t    it;
    int unsigned   len;
    int unsigned   steps;
    int unsigned   pick;
    int unsigned   random_goal;
    int unsigned   next_mode_change;
    int unsigned   next_hold;
    rst               <= 1'b1;
    line_if.valid     <= 1'b0;
    line_if.operation <= OP_LOAD;
    line_if.x_start   <= '0;
    line_if.y_start   <= '0;
    line_if.x_end     <= '0;
    line_if.y_end     <= '0;
    line_if.red_in    <= '0;
    line_if.green_in  <= '0;
    line_if.blue_in   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Step with no line loaded gives nothing.
    directed_rows.push_back('{random_item(OP_STEP), 1'b0, '0});
    // Single point at the far screen corner: one pixel, flagged last.
    directed_rows.push_back('{load_item(639, 479, 639, 479, 8'hff, 8'h00, 8'h80), 1'b0, '0});
    directed_rows.push_back('{random_item(OP_STEP), 1'b1,
                              pixel_t'{10'd639, 9'd479, 19'd307199, 8'hff, 8'h00, 8'h80, 1'b1}});
    directed_rows.push_back('{random_item(OP_STEP), 1'b0, '0});
    // Horizontal line from the origin, replaced by a new load before it ends.
    directed_rows.push_back('{load_item(0, 0, 2, 0, 8'h00, 8'hff, 8'h00), 1'b0, '0});
    directed_rows.push_back('{random_item(OP_STEP), 1'b1,
                              pixel_t'{10'd0, 9'd0, 19'd0, 8'h00, 8'hff, 8'h00, 1'b0}});
    directed_rows.push_back('{random_item(OP_STEP), 1'b1,
                              pixel_t'{10'd1, 9'd0, 19'd1, 8'h00, 8'hff, 8'h00, 1'b0}});
    // Right-to-left endpoints with a falling row.
    directed_rows.push_back('{load_item(10, 5, 5, 9, 8'haa, 8'h55, 8'hff), 1'b0, '0});
    repeat (6) directed_rows.push_back('{random_item(OP_STEP), 1'b0, '0});
    // Steepest line: two pixels spanning the full row range.
    directed_rows.push_back('{load_item(100, 0, 101, 479, 8'h12, 8'h34, 8'h56), 1'b0, '0});
    directed_rows.push_back('{random_item(OP_STEP), 1'b1,
                              pixel_t'{10'd100, 9'd0, 19'd100, 8'h12, 8'h34, 8'h56, 1'b0}});
    directed_rows.push_back('{random_item(OP_STEP), 1'b1,
                              pixel_t'{10'd101, 9'd479, 19'd306661, 8'h12, 8'h34, 8'h56, 1'b1}});
    // Vertical line walking upward in rows.
    directed_rows.push_back('{load_item(7, 20, 7, 17, 8'hff, 8'hff, 8'hff), 1'b0, '0});
    repeat (4) directed_rows.push_back('{random_item(OP_STEP), 1'b0, '0});
    // Off-screen coordinates at the top of the field widths.
    directed_rows.push_back('{load_item(1023, 511, 1020, 0, 8'h00, 8'h00, 8'h00), 1'b0, '0});
    repeat (2) directed_rows.push_back('{random_item(OP_STEP), 1'b0, '0});

    foreach (directed_rows[i]) begin
      send_line_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].pinned_px);
    end
    hold_until_drained();

    // Random part: mostly whole lines with their steps, some noise and cut-short walks.
    random_goal      = items_sent + RANDOM_ITEMS;
    next_mode_change = items_sent;
    next_hold        = items_sent + $urandom_range(150, 300);
    while (items_sent < random_goal) begin
      if (items_sent >= next_mode_change) begin
        no_idle          = ($urandom_range(0, 3) == 0);
        next_mode_change = items_sent + 64;
      end
      if (items_sent >= next_hold) begin
        hold_until_drained();
        next_hold = items_sent + $urandom_range(150, 300);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        make_random_line(it, len);
        send_line_item(it, 1'b0, '0);
        steps = len;
        pick  = $urandom_range(0, 9);
        if (pick == 0) begin
          steps = $urandom_range(0, len - 1);
        end else if (pick == 1) begin
          steps = len + $urandom_range(1, 3);
        end
        repeat (steps) send_line_item(random_item(OP_STEP), 1'b0, '0);
      end else if (pick < 90) begin
        send_line_item(random_item(OP_STEP), 1'b0, '0);
      end else begin
        send_line_item(random_item(logic'($urandom_range(0, 1))), 1'b0, '0);
      end
    end
    hold_until_drained();

    $display("Drove %0d items including %0d line loads; checked %0d pixels, %0d mismatches.",
             items_sent, lines_loaded, pixels_seen, errors);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("tb_line_pixel_generator_core: PASS");
    end else begin
      $display("tb_line_pixel_generator_core: FAIL");
    end
    $finish;
  end

endmodule

@@ line_pixel_generator_core.f @@
rtl/lpg_pkg.sv
rtl/lpg_in_if.sv
rtl/lpg_out_if.sv
rtl/lpg_divider.sv
rtl/line_pixel_generator_core.sv
tb/tb_line_pixel_generator_core.sv
